>>> src/brsc_pkg.sv
// Shared constants, deque entry layout and controller/datapath handshake types
// for the bounded-range subarray counter. No dependencies.
package brsc_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int RANGE_W     = 16;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int POS_W       = $clog2(MAX_LEN + 1);
  localparam int HERE_W      = 11;
  localparam int TOTAL_W     = 20;
  localparam int DIFF_W      = ((SAMPLE_BITS > RANGE_W) ? SAMPLE_BITS : RANGE_W) + 2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [IDX_W-1:0]              pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic front_sel;
    logic min_pop_tail;
    logic min_push;
    logic max_pop_tail;
    logic max_push;
    logic step_edge;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic min_empty;
    logic max_empty;
    logic min_pop;
    logic max_pop;
    logic too_wide;
    logic out_free;
  } status_t;

endpackage

>>> src/brsc_in_if.sv
// Input channel of the subarray counter: valid/ready plus one sample beat.
// Depends on nothing.
interface brsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               first;
  logic               last;

  modport source (output valid, sample, first, last, input ready);
  modport sink   (input valid, sample, first, last, output ready);
endinterface

>>> src/brsc_out_if.sv
// Result channel of the subarray counter: valid/ready plus one result beat.
// Depends on nothing.
interface brsc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] ending_here;
  logic [19:0] running_total;
  logic        overflow;
  logic        done_res;

  modport source (output valid, ending_here, running_total, overflow, done_res,
                  input ready);
  modport sink   (input valid, ending_here, running_total, overflow, done_res,
                  output ready);
endinterface

>>> src/bounded_range_subarray_counter_top.sv
// Bounded-range subarray counter.
// A sample beat arrives on in_ch (sample, first, last); for each one a single
// result beat leaves on out_ch: ending_here, the number of subarrays ending at
// that sample whose max - min stays within range_limit, running_total for the
// sequence, overflow and done_res (copy of last).
// range_limit is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while idle, as the block does not enforce it. first clears the window
// before its sample; after MAX_LEN samples of one sequence further samples are
// ignored and reported with overflow set. A sample is captured in IDLE;
// PUSH_RD reads the deque backs, PUSH_CMP pops or pushes, FRONT_RD reads both
// deque fronts from RAM, FRONT_CHK compares and FINISH loads the result (an
// ignored sample goes from PUSH_RD to FINISH). Each round of back pops repeats
// PUSH_RD/PUSH_CMP and each left-edge step FRONT_RD/FRONT_CHK, amortized near
// one each per sample. Input is taken again in the cycle after the load.
// in_ch.ready is high while the sequencer is idle; the result sits in its own
// register, so the next sample is taken while an earlier result still waits.
// A stalled out_ch holds the result and the sequencer waits before loading
// the next one. Reset (rst, synchronous) empties both deques, clears counters,
// range_limit and the result valid. Deque storage needs no clearing pass.
// Depends on brsc_pkg, brsc_in_if, brsc_out_if, brsc_ctrl, brsc_datapath.
module bounded_range_subarray_counter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [brsc_pkg::RANGE_W-1:0] cfg_wr_data,
  brsc_in_if.sink                      in_ch,
  brsc_out_if.source                   out_ch
);

  brsc_pkg::cmd_t    cmd;
  brsc_pkg::status_t st;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  brsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  brsc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sample        (in_ch.sample),
    .first         (in_ch.first),
    .last          (in_ch.last),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .ending_here   (out_ch.ending_here),
    .running_total (out_ch.running_total),
    .overflow      (out_ch.overflow),
    .done_res      (out_ch.done_res)
  );

endmodule

>>> src/brsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/brsc_ctrl.sv
// Sequencer of the subarray counter: drives deque push, window shrink and
// result hand-off. Depends on brsc_pkg.
module brsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  brsc_pkg::status_t st,
  output brsc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PUSH_RD,
    PUSH_CMP,
    FRONT_RD,
    FRONT_CHK,
    FINISH
  } state_t;

  state_t state, state_next;
  logic   min_done, min_done_next;
  logic   max_done, max_done_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    min_done_next = min_done;
    max_done_next = max_done;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          min_done_next = 1'b0;
          max_done_next = 1'b0;
          state_next    = PUSH_RD;
        end
      end
      PUSH_RD: begin
        // an ignored sample goes straight to the result
        state_next = st.ovf ? FINISH : PUSH_CMP;
      end
      PUSH_CMP: begin
        if (!min_done) begin
          if (!st.min_empty && st.min_pop) begin
            cmd.min_pop_tail = 1'b1;
          end else begin
            cmd.min_push  = 1'b1;
            min_done_next = 1'b1;
          end
        end
        if (!max_done) begin
          if (!st.max_empty && st.max_pop) begin
            cmd.max_pop_tail = 1'b1;
          end else begin
            cmd.max_push  = 1'b1;
            max_done_next = 1'b1;
          end
        end
        state_next = (min_done_next && max_done_next) ? FRONT_RD : PUSH_RD;
      end
      FRONT_RD: begin
        cmd.front_sel = 1'b1;
        state_next    = FRONT_CHK;
      end
      FRONT_CHK: begin
        if (st.too_wide) begin
          cmd.step_edge = 1'b1;
          state_next    = FRONT_RD;
        end else begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      min_done <= 1'b0;
      max_done <= 1'b0;
    end else begin
      state    <= state_next;
      min_done <= min_done_next;
      max_done <= max_done_next;
    end
  end

  property p_load_only_in_finish;
    @(posedge clk) disable iff (rst) cmd.load_out |-> $past(state_next) == FINISH;
  endproperty
  a_load_only_in_finish: assert property (p_load_only_in_finish)
    else $error("result loaded outside the finish step");

  property p_push_once;
    @(posedge clk) disable iff (rst) (state == PUSH_CMP && min_done) |-> !cmd.min_push;
  endproperty
  a_push_once: assert property (p_push_once)
    else $error("second push into the min deque for one sample");

  property p_capture_idle;
    @(posedge clk) disable iff (rst) cmd.capture |=> state == PUSH_RD && !min_done && !max_done;
  endproperty
  a_capture_idle: assert property (p_capture_idle)
    else $error("sample capture did not start the push phase");

endmodule

>>> src/brsc_datapath.sv
// Deque storage, window pointers, counters and result register of the
// subarray counter. Depends on brsc_pkg and brsc_ram.
module brsc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [brsc_pkg::RANGE_W-1:0]    cfg_wr_data,
  input  logic signed [15:0]              sample,
  input  logic                            first,
  input  logic                            last,
  input  brsc_pkg::cmd_t                  cmd,
  output brsc_pkg::status_t               st,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [brsc_pkg::HERE_W-1:0]     ending_here,
  output logic [brsc_pkg::TOTAL_W-1:0]    running_total,
  output logic                            overflow,
  output logic                            done_res
);

  localparam int IDX_W    = brsc_pkg::IDX_W;
  localparam int POS_W    = brsc_pkg::POS_W;
  localparam int HERE_W_L = brsc_pkg::HERE_W;

  logic [brsc_pkg::RANGE_W-1:0]          range_limit;
  logic signed [brsc_pkg::SAMPLE_BITS-1:0] sample_r;
  logic                                  last_r;
  logic                                  ovf_r;
  logic [IDX_W-1:0]                      min_head, max_head;
  logic [POS_W-1:0]                      min_count, max_count;
  logic [IDX_W-1:0]                      left_edge;
  logic [POS_W-1:0]                      position;
  logic [brsc_pkg::TOTAL_W-1:0]          total;

  logic [IDX_W-1:0]                      min_raddr, max_raddr, min_waddr, max_waddr;
  logic [brsc_pkg::ENTRY_W-1:0]          min_rdata, max_rdata;
  brsc_pkg::entry_t                      min_e, max_e, push_e;
  logic signed [brsc_pkg::DIFF_W-1:0]    max_x, min_x, diff, limit_x;
  logic [HERE_W_L-1:0]                   here;

  assign min_e  = brsc_pkg::entry_t'(min_rdata);
  assign max_e  = brsc_pkg::entry_t'(max_rdata);
  assign push_e = '{val: sample_r, pos: position[IDX_W-1:0]};

  // back slot is head + count - 1, push slot is head + count
  assign min_waddr = IDX_W'(min_head + min_count[IDX_W-1:0]);
  assign max_waddr = IDX_W'(max_head + max_count[IDX_W-1:0]);
  assign min_raddr = cmd.front_sel ? min_head : IDX_W'(min_waddr - 1'b1);
  assign max_raddr = cmd.front_sel ? max_head : IDX_W'(max_waddr - 1'b1);

  brsc_ram #(.WIDTH(brsc_pkg::ENTRY_W), .DEPTH(brsc_pkg::MAX_LEN)) u_min_ram (
    .clk   (clk),
    .we    (cmd.min_push),
    .waddr (min_waddr),
    .wdata (push_e),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  brsc_ram #(.WIDTH(brsc_pkg::ENTRY_W), .DEPTH(brsc_pkg::MAX_LEN)) u_max_ram (
    .clk   (clk),
    .we    (cmd.max_push),
    .waddr (max_waddr),
    .wdata (push_e),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  assign max_x   = brsc_pkg::DIFF_W'(max_e.val);
  assign min_x   = brsc_pkg::DIFF_W'(min_e.val);
  assign diff    = max_x - min_x;
  assign limit_x = brsc_pkg::DIFF_W'(range_limit);
  assign here    = HERE_W_L'(position - POS_W'(left_edge) + 1'b1);

  always_comb begin
    st           = '0;
    st.ovf       = ovf_r;
    st.min_empty = (min_count == '0);
    st.max_empty = (max_count == '0);
    st.min_pop   = (min_e.val >= sample_r);
    st.max_pop   = (max_e.val <= sample_r);
    st.too_wide  = (diff > limit_x);
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample[brsc_pkg::SAMPLE_BITS-1:0];
      last_r   <= last;
      ovf_r    <= !first && (position == POS_W'(brsc_pkg::MAX_LEN));
    end
    if (cmd.load_out) begin
      ending_here   <= ovf_r ? '0 : here;
      running_total <= ovf_r ? total : brsc_pkg::TOTAL_W'(total + here);
      overflow      <= ovf_r;
      done_res      <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= '0;
      min_head    <= '0;
      max_head    <= '0;
      min_count   <= '0;
      max_count   <= '0;
      left_edge   <= '0;
      position    <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        range_limit <= cfg_wr_data;
      end
      if (cmd.capture && first) begin
        min_head  <= '0;
        max_head  <= '0;
        min_count <= '0;
        max_count <= '0;
        left_edge <= '0;
        position  <= '0;
        total     <= '0;
      end
      if (cmd.min_pop_tail) begin
        min_count <= min_count - 1'b1;
      end
      if (cmd.min_push) begin
        min_count <= min_count + 1'b1;
      end
      if (cmd.max_pop_tail) begin
        max_count <= max_count - 1'b1;
      end
      if (cmd.max_push) begin
        max_count <= max_count + 1'b1;
      end
      if (cmd.step_edge) begin
        // advance the edge and drop fronts that fall behind it
        left_edge <= left_edge + 1'b1;
        if (min_count != '0 && min_e.pos <= left_edge) begin
          min_head  <= min_head + 1'b1;
          min_count <= min_count - 1'b1;
        end
        if (max_count != '0 && max_e.pos <= left_edge) begin
          max_head  <= max_head + 1'b1;
          max_count <= max_count - 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (!ovf_r) begin
          total    <= brsc_pkg::TOTAL_W'(total + here);
          position <= position + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst)
      min_count <= POS_W'(brsc_pkg::MAX_LEN) && max_count <= POS_W'(brsc_pkg::MAX_LEN);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("deque holds more entries than its storage");

  property p_edge_behind_sample;
    @(posedge clk) disable iff (rst) cmd.step_edge |-> POS_W'(left_edge) < position;
  endproperty
  a_edge_behind_sample: assert property (p_edge_behind_sample)
    else $error("left edge advanced past the newest sample");

  property p_fronts_live;
    @(posedge clk) disable iff (rst)
      cmd.step_edge |-> min_count != '0 && max_count != '0;
  endproperty
  a_fronts_live: assert property (p_fronts_live)
    else $error("window check on an empty deque");

  property p_no_overwrite;
    @(posedge clk) disable iff (rst) cmd.load_out |-> !out_valid || out_ready;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("result register overwritten before it was taken");

endmodule
